// File: design/cem_pkg.sv
// Shared types, codes and constants of the chat expect matcher.
`default_nettype none

package cem_pkg;

    localparam int PATTERN_CHARS_DEF = 8;
    localparam int PAT_BYTES = 8;
    localparam int PAT_W = 64;
    localparam int LEN_W = 4;
    localparam int TICK_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CHAR_W = 7;

    localparam logic [1:0] CMD_BYTE = 2'd0;
    localparam logic [1:0] CMD_TICK = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_EXP_PAT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXP_LEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ABT_PAT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ABT_LEN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ABT_EN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 3'd5;

    localparam logic [TICK_W-1:0] TIMEOUT_DEF = 16'd45;
    localparam logic [7:0] WILDCARD = 8'h3F;

    typedef enum logic [2:0] {
        ST_WAIT = 3'd0,
        ST_MATCH = 3'd1,
        ST_ABORT = 3'd2,
        ST_TIMEOUT = 3'd3,
        ST_IDLE = 3'd4
    } status_t;

    function automatic logic char_hit(input logic [7:0] pat, input logic [CHAR_W-1:0] ch);
        return (pat == WILDCARD) || (pat == {1'b0, ch});
    endfunction

endpackage

`default_nettype wire

// File: design/chat_expect_matcher_core.sv
// Top level of the chat expect matcher: history shift line, pattern compare and status.
`default_nettype none

// The input channel (in_valid, in_ready, command, received_byte) takes one word per
// cycle: a received byte, a timer tick or a start command. Every accepted word
// yields exactly one status word on the output channel (out_valid, out_ready,
// status) in the next cycle, from a single output register. A byte is masked to seven
// bits; null bytes are dropped. The newest characters sit in a shift line, and all
// candidate pattern lengths are compared in parallel in the same cycle, so the
// sustained rate is one word per cycle. When the receiver stalls, the status word
// holds and in_ready drops until it is taken; in_ready stays high while the output
// register is empty or being emptied. Reset leaves the block idle with an empty
// output and the configuration registers at their defaults (timeout of 45 ticks).
// Configuration writes through cfg_we, cfg_index and cfg_data take effect on the
// next cycle and carry no wait.
module chat_expect_matcher_core #(
    parameter int PATTERN_CHARS = cem_pkg::PATTERN_CHARS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [cem_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [cem_pkg::PAT_W-1:0]      cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [1:0]                     command,
    input  wire logic [7:0]                     received_byte,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [2:0]                          status
);
    import cem_pkg::*;

    localparam int LMAX = (PATTERN_CHARS < 15) ? PATTERN_CHARS : 15;
    localparam int LEN_SEL_W = (LMAX > 1) ? $clog2(LMAX + 1) : 1;
    localparam int FILL_W = $clog2(PATTERN_CHARS + 1);

    logic [PAT_W-1:0]   exp_pat_reg;
    logic [LEN_W-1:0]   exp_len_reg;
    logic [PAT_W-1:0]   abt_pat_reg;
    logic [LEN_W-1:0]   abt_len_reg;
    logic               abt_en_reg;
    logic [TICK_W-1:0]  timeout_reg;

    logic [CHAR_W-1:0]  hist_reg [PATTERN_CHARS];
    logic [CHAR_W-1:0]  hist_next [PATTERN_CHARS];
    logic [CHAR_W-1:0]  hist_sh [PATTERN_CHARS];
    logic [FILL_W-1:0]  fill_reg;
    logic [FILL_W-1:0]  fill_next;
    logic [FILL_W-1:0]  fill_sh;
    logic [TICK_W-1:0]  ticks_reg;
    logic [TICK_W-1:0]  ticks_next;
    logic               searching_reg;
    logic               searching_next;
    logic               out_valid_reg;
    status_t            status_reg;
    status_t            status_next;

    logic [7:0]         exp_byte [LMAX];
    logic [7:0]         abt_byte [LMAX];
    logic [LMAX:0]      exp_ok;
    logic [LMAX:0]      abt_ok;
    logic [LEN_SEL_W-1:0] exp_sel;
    logic [LEN_SEL_W-1:0] abt_sel;
    logic               exp_hit;
    logic               abt_hit;
    logic [CHAR_W-1:0]  ch;
    logic               accept;

    assign ch = received_byte[CHAR_W-1:0];
    assign in_ready = !out_valid_reg || out_ready;
    assign accept = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign status = status_reg;

    for (genvar g = 0; g < LMAX; g++) begin : g_bytes
        if (g < PAT_BYTES) begin : g_in
            assign exp_byte[g] = exp_pat_reg[8*g +: 8];
            assign abt_byte[g] = abt_pat_reg[8*g +: 8];
        end else begin : g_out
            assign exp_byte[g] = '0;
            assign abt_byte[g] = '0;
        end
    end

    always_comb
    begin
        hist_sh[0] = ch;
        for (int k = 1; k < PATTERN_CHARS; k++)
        begin
            hist_sh[k] = hist_reg[k-1];
        end
        fill_sh = (fill_reg == FILL_W'(PATTERN_CHARS)) ? fill_reg : fill_reg + 1'b1;
    end

    always_comb
    begin
        for (int n = 0; n <= LMAX; n++)
        begin
            exp_ok[n] = (int'(fill_sh) >= n);
            abt_ok[n] = (int'(fill_sh) >= n);
            for (int i = 0; i < LMAX; i++)
            begin
                if (i < n)
                begin
                    exp_ok[n] = exp_ok[n] && char_hit(exp_byte[i], hist_sh[n-1-i]);
                    abt_ok[n] = abt_ok[n] && char_hit(abt_byte[i], hist_sh[n-1-i]);
                end
            end
        end
    end

    always_comb
    begin
        if (32'(exp_len_reg) > LMAX)
            exp_sel = LEN_SEL_W'(LMAX);
        else
            exp_sel = exp_len_reg[LEN_SEL_W-1:0];
        if (32'(abt_len_reg) > LMAX)
            abt_sel = LEN_SEL_W'(LMAX);
        else
            abt_sel = abt_len_reg[LEN_SEL_W-1:0];
        exp_hit = exp_ok[exp_sel];
        abt_hit = abt_en_reg && ((abt_len_reg == '0) || abt_ok[abt_sel]);
    end

    always_comb
    begin
        hist_next = hist_reg;
        fill_next = fill_reg;
        ticks_next = ticks_reg;
        searching_next = searching_reg;
        status_next = ST_WAIT;
        if (command == CMD_START)
        begin
            for (int k = 0; k < PATTERN_CHARS; k++)
            begin
                hist_next[k] = '0;
            end
            fill_next = '0;
            ticks_next = timeout_reg;
            searching_next = (exp_len_reg != '0);
            status_next = (exp_len_reg == '0) ? ST_MATCH : ST_WAIT;
        end
        else if (!searching_reg)
        begin
            status_next = ST_IDLE;
        end
        else if (command == CMD_TICK)
        begin
            if (ticks_reg <= TICK_W'(1))
            begin
                ticks_next = '0;
                searching_next = 1'b0;
                status_next = ST_TIMEOUT;
            end
            else
            begin
                ticks_next = ticks_reg - 1'b1;
            end
        end
        else if (command == CMD_BYTE && ch != '0)
        begin
            hist_next = hist_sh;
            fill_next = fill_sh;
            if (exp_hit)
            begin
                searching_next = 1'b0;
                status_next = ST_MATCH;
            end
            else if (abt_hit)
            begin
                searching_next = 1'b0;
                status_next = ST_ABORT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_pat_reg <= '0;
            exp_len_reg <= '0;
            abt_pat_reg <= '0;
            abt_len_reg <= '0;
            abt_en_reg <= 1'b0;
            timeout_reg <= TIMEOUT_DEF;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_EXP_PAT: exp_pat_reg <= cfg_data;
                REG_EXP_LEN: exp_len_reg <= cfg_data[LEN_W-1:0];
                REG_ABT_PAT: abt_pat_reg <= cfg_data;
                REG_ABT_LEN: abt_len_reg <= cfg_data[LEN_W-1:0];
                REG_ABT_EN:  abt_en_reg <= cfg_data[0];
                REG_TIMEOUT: timeout_reg <= cfg_data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            ticks_reg <= '0;
            searching_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                fill_reg <= fill_next;
                ticks_reg <= ticks_next;
                searching_reg <= searching_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hist_reg <= hist_next;
            status_reg <= status_next;
        end
    end

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= PATTERN_CHARS)
        else $error("History fill count exceeds the shift line depth.");

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && command == CMD_START |=> fill_reg == '0)
        else $error("Start did not clear the history.");

    a_idle_status: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !searching_reg && (command == CMD_BYTE || command == CMD_TICK)
        |=> status_reg == ST_IDLE && !searching_reg)
        else $error("Idle word did not report idle.");

    a_timeout: assert property (@(posedge clk) disable iff (!rst_n)
        accept && searching_reg && command == CMD_TICK && ticks_reg <= TICK_W'(1)
        |=> status_reg == ST_TIMEOUT && !searching_reg && ticks_reg == '0)
        else $error("Last tick did not end the search with a timeout.");
`endif

endmodule

`default_nettype wire
